// ===== hdl/mesh_directed_edge_dedup_defines.svh =====
// Shared assertion macros. They expect signals named clock and reset in scope.
`ifndef MESH_DIRECTED_EDGE_DEDUP_DEFINES_SVH
`define MESH_DIRECTED_EDGE_DEDUP_DEFINES_SVH

// Same-cycle implication.
`define MDED_ASSERT_IMPL(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("mded: same-cycle check failed");

// Next-cycle implication.
`define MDED_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("mded: next-cycle check failed");

`endif

// ===== hdl/mded_pkg.sv =====
package mded_pkg;

   localparam int VERTEX_W     = 16;
   localparam int EDGE_INDEX_W = 12;
   localparam int EDGE_TOTAL_W = 13;
   localparam int EPOCH_W      = 8;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // One directed edge as handed from the front end to the lookup engine.
   typedef struct packed {
      logic [VERTEX_W-1:0] start_vertex;
      logic [VERTEX_W-1:0] end_vertex;
      logic                last;
      logic                clear;
   } edge_cmd_type;

endpackage

// ===== hdl/mded_ifs.sv =====
interface mded_req_if;
   logic                           valid;
   logic                           ready;
   logic [mded_pkg::VERTEX_W-1:0]  vertex_a;
   logic [mded_pkg::VERTEX_W-1:0]  vertex_b;
   logic [mded_pkg::VERTEX_W-1:0]  vertex_c;
   logic                           new_mesh;

   modport source (output valid, vertex_a, vertex_b, vertex_c, new_mesh, input ready);
   modport sink   (input valid, vertex_a, vertex_b, vertex_c, new_mesh, output ready);
endinterface

interface mded_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mded_pkg::EDGE_INDEX_W-1:0]  edge_index;
   logic [mded_pkg::VERTEX_W-1:0]      start_vertex;
   logic [mded_pkg::VERTEX_W-1:0]      end_vertex;
   logic                               is_new;
   logic                               dropped;
   logic [mded_pkg::EDGE_TOTAL_W-1:0]  edge_total;
   logic                               last_of_triangle;

   modport source (output valid, edge_index, start_vertex, end_vertex, is_new, dropped,
                   edge_total, last_of_triangle, input ready);
   modport sink   (input valid, edge_index, start_vertex, end_vertex, is_new, dropped,
                   edge_total, last_of_triangle, output ready);
endinterface

// ===== hdl/mded_ram.sv =====
module mded_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== hdl/mded_queue.sv =====
module mded_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mded_pkg::edge_cmd_type push_cmd,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output mded_pkg::edge_cmd_type head
);
   localparam int PW = mded_pkg::QUEUE_PTR_W;
   localparam int CW = mded_pkg::QUEUE_CNT_W;

   mded_pkg::edge_cmd_type slots_ff [mded_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      full      = (count_ff == CW'(mded_pkg::QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = slots_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

// ===== hdl/mded_front.sv =====
module mded_front (
   input  logic                   clock,
   input  logic                   reset,
   mded_req_if.sink               req_ch,
   input  logic                   clearing,
   output logic                   push,
   output mded_pkg::edge_cmd_type push_cmd,
   input  logic                   full
);
   localparam int VW = mded_pkg::VERTEX_W;

   logic          busy_ff, busy_in;
   logic [1:0]    sel_ff, sel_in;
   logic [VW-1:0] va_ff, vb_ff, vc_ff;
   logic          nm_ff;
   logic          accept;

   always_comb begin
      req_ch.ready = !busy_ff && !clearing;
      accept       = req_ch.valid && req_ch.ready;
      push         = busy_ff && !full;
      push_cmd     = '0;
      case (sel_ff)
         2'd0: begin
            push_cmd.start_vertex = va_ff;
            push_cmd.end_vertex   = vb_ff;
            push_cmd.clear        = nm_ff;
         end
         2'd1: begin
            push_cmd.start_vertex = vb_ff;
            push_cmd.end_vertex   = vc_ff;
         end
         default: begin
            push_cmd.start_vertex = vc_ff;
            push_cmd.end_vertex   = va_ff;
            push_cmd.last         = 1'b1;
         end
      endcase
      busy_in = busy_ff;
      sel_in  = sel_ff;
      if (accept) begin
         busy_in = 1'b1;
         sel_in  = '0;
      end else if (push) begin
         sel_in = sel_ff + 1'b1;
         if (sel_ff == 2'd2) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sel_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sel_ff  <= sel_in;
      end
      if (accept) begin
         va_ff <= req_ch.vertex_a;
         vb_ff <= req_ch.vertex_b;
         vc_ff <= req_ch.vertex_c;
         nm_ff <= req_ch.new_mesh;
      end
   end
endmodule

// ===== hdl/mded_back.sv =====
`include "mesh_directed_edge_dedup_defines.svh"

module mded_back #(
   parameter int EDGE_CAPACITY = 4096,
   parameter int HASH_SLOTS    = 8192,
   parameter int VERTEX_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  mded_pkg::edge_cmd_type head,
   output logic                   pop,
   output logic                   clearing,
   mded_rsp_if.source             rsp_ch
);
   localparam int VB     = VERTEX_BITS;
   localparam int KEY_W  = 2 * VB;
   localparam int SLOT_W = $clog2(HASH_SLOTS);
   localparam int PRB_W  = $clog2(HASH_SLOTS + 1);
   localparam int IDX_W  = $clog2(EDGE_CAPACITY);
   localparam int CNT_W  = $clog2(EDGE_CAPACITY + 1);
   localparam int EP_W   = mded_pkg::EPOCH_W;
   localparam int RAM_W  = EP_W + IDX_W + KEY_W;
   localparam int VW     = mded_pkg::VERTEX_W;
   localparam int OIW    = mded_pkg::EDGE_INDEX_W;
   localparam int OTW    = mded_pkg::EDGE_TOTAL_W;

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_OUT} state_type;

   state_type     state_ff, state_in;
   logic [EP_W-1:0]   epoch_ff, epoch_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] clr_ff, clr_in, pos_ff, pos_in;
   logic [PRB_W-1:0]  probes_ff, probes_in;
   logic              pend_ff, pend_in;
   mded_pkg::edge_cmd_type cur_ff, cur_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic              res_new_ff, res_new_in, res_drop_ff, res_drop_in;
   logic              o_valid_ff, o_valid_in;
   logic [OIW-1:0]    o_idx_ff, o_idx_in;
   logic [VW-1:0]     o_start_ff, o_start_in, o_end_ff, o_end_in;
   logic              o_new_ff, o_new_in, o_drop_ff, o_drop_in, o_last_ff, o_last_in;
   logic [OTW-1:0]    o_total_ff, o_total_in;

   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr, ram_raddr, next_pos;
   logic [RAM_W-1:0]  ram_wdata, ram_rdata;
   logic [EP_W-1:0]   rd_epoch, epoch_next;
   logic [IDX_W-1:0]  rd_idx;
   logic [KEY_W-1:0]  rd_key, cur_key;
   logic [VB-1:0]     cur_s, cur_e, head_s, head_e;
   logic              out_free;

   // Rotating xor fold of the key, then one conditional subtract into range.
   function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] k);
      logic [SLOT_W:0] h;
      h = '0;
      for (int i = 0; i < KEY_W; i++) begin
         h[(i * 7) % SLOT_W] = h[(i * 7) % SLOT_W] ^ k[i];
      end
      if (h >= (SLOT_W + 1)'(HASH_SLOTS)) begin
         h = h - (SLOT_W + 1)'(HASH_SLOTS);
      end
      return h[SLOT_W-1:0];
   endfunction

   mded_ram #(.WIDTH(RAM_W), .DEPTH(HASH_SLOTS)) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      head_s   = VB'(head.start_vertex);
      head_e   = VB'(head.end_vertex);
      cur_s    = VB'(cur_ff.start_vertex);
      cur_e    = VB'(cur_ff.end_vertex);
      cur_key  = {cur_e, cur_s};
      rd_key   = ram_rdata[KEY_W-1:0];
      rd_idx   = ram_rdata[KEY_W +: IDX_W];
      rd_epoch = ram_rdata[RAM_W-1 -: EP_W];
      next_pos = (pos_ff == SLOT_W'(HASH_SLOTS - 1)) ? '0 : pos_ff + 1'b1;
      epoch_next = epoch_ff + 1'b1;
      out_free = !o_valid_ff || rsp_ch.ready;
      clearing = (state_ff == S_CLEAR);

      state_in    = state_ff;
      epoch_in    = epoch_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      pos_in      = pos_ff;
      probes_in   = probes_ff;
      pend_in     = pend_ff;
      cur_in      = cur_ff;
      res_idx_in  = res_idx_ff;
      res_new_in  = res_new_ff;
      res_drop_in = res_drop_ff;
      o_valid_in  = o_valid_ff && !rsp_ch.ready;
      o_idx_in    = o_idx_ff;
      o_start_in  = o_start_ff;
      o_end_in    = o_end_ff;
      o_new_in    = o_new_ff;
      o_drop_in   = o_drop_ff;
      o_total_in  = o_total_ff;
      o_last_in   = o_last_ff;
      pop         = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = pos_ff;
      ram_wdata   = {epoch_ff, IDX_W'(cnt_ff), cur_key};
      ram_raddr   = pos_ff;

      case (state_ff)
         S_CLEAR: begin
            // epoch zero marks a slot as empty
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(HASH_SLOTS - 1)) begin
               clr_in   = '0;
               epoch_in = EP_W'(1);
               pend_in  = 1'b0;
               state_in = pend_ff ? S_READ : S_IDLE;
            end
         end
         S_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               cur_in    = head;
               pos_in    = slot_hash({head_e, head_s});
               ram_raddr = pos_in;
               probes_in = PRB_W'(1);
               state_in  = S_CHECK;
               if (head.clear) begin
                  cnt_in = '0;
                  if (epoch_next == '0) begin
                     pend_in  = 1'b1;
                     state_in = S_CLEAR;
                  end else begin
                     epoch_in = epoch_next;
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            res_idx_in  = '0;
            res_new_in  = 1'b0;
            res_drop_in = 1'b0;
            state_in    = S_OUT;
            if (rd_epoch != epoch_ff) begin
               if (cnt_ff < CNT_W'(EDGE_CAPACITY)) begin
                  ram_we     = 1'b1;
                  res_idx_in = IDX_W'(cnt_ff);
                  res_new_in = 1'b1;
                  cnt_in     = cnt_ff + 1'b1;
               end else begin
                  res_drop_in = 1'b1;
               end
            end else if (rd_key == cur_key) begin
               res_idx_in = rd_idx;
            end else if (probes_ff == PRB_W'(HASH_SLOTS)) begin
               res_drop_in = 1'b1;
            end else begin
               pos_in    = next_pos;
               ram_raddr = next_pos;
               probes_in = probes_ff + 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_OUT: begin
            if (out_free) begin
               o_valid_in = 1'b1;
               o_idx_in   = OIW'(res_idx_ff);
               o_start_in = VW'(cur_s);
               o_end_in   = VW'(cur_e);
               o_new_in   = res_new_ff;
               o_drop_in  = res_drop_ff;
               o_total_in = OTW'(cnt_ff);
               o_last_in  = cur_ff.last;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_ch.valid            = o_valid_ff;
      rsp_ch.edge_index       = o_idx_ff;
      rsp_ch.start_vertex     = o_start_ff;
      rsp_ch.end_vertex       = o_end_ff;
      rsp_ch.is_new           = o_new_ff;
      rsp_ch.dropped          = o_drop_ff;
      rsp_ch.edge_total       = o_total_ff;
      rsp_ch.last_of_triangle = o_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         epoch_ff   <= EP_W'(1);
         cnt_ff     <= '0;
         clr_ff     <= '0;
         pend_ff    <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         epoch_ff   <= epoch_in;
         cnt_ff     <= cnt_in;
         clr_ff     <= clr_in;
         pend_ff    <= pend_in;
         o_valid_ff <= o_valid_in;
      end
      pos_ff      <= pos_in;
      probes_ff   <= probes_in;
      cur_ff      <= cur_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_drop_ff <= res_drop_in;
      o_idx_ff    <= o_idx_in;
      o_start_ff  <= o_start_in;
      o_end_ff    <= o_end_in;
      o_new_ff    <= o_new_in;
      o_drop_ff   <= o_drop_in;
      o_total_ff  <= o_total_in;
      o_last_ff   <= o_last_in;
   end

   `MDED_ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_ff <= CNT_W'(EDGE_CAPACITY))
   `MDED_ASSERT_NEXT(a_insert_counts, (state_ff == S_CHECK) && ram_we, cnt_ff == $past(cnt_ff) + 1'b1)
   `MDED_ASSERT_IMPL(a_epoch_live, state_ff != S_CLEAR, epoch_ff != '0)
   `MDED_ASSERT_IMPL(a_no_pop_busy, pop, state_ff == S_IDLE)
endmodule

// ===== hdl/mesh_directed_edge_dedup.sv =====
// channel   dir  moves
// req_ch    in   one triangle (three vertices, new_mesh) per transaction
// rsp_ch    out  one directed edge result per transaction, three per triangle
//
// Each edge passes the lookup engine states S_IDLE, S_CHECK and S_OUT, staying
// in S_CHECK for each extra probe of the slot RAM (one read port, one write port).
// After reset, and when the 8-bit table epoch wraps on new_mesh, the slot RAM
// is swept through all HASH_SLOTS slots and req_ch.ready stays low meanwhile.
// A four-entry edge queue lets triangle intake run ahead of lookups.
// rsp_ch has an output register; a stalled result holds the lookup engine, and intake stops once the queue is full.
module mesh_directed_edge_dedup #(
   parameter int EDGE_CAPACITY = 4096,
   parameter int HASH_SLOTS    = 8192,
   parameter int VERTEX_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   mded_req_if.sink   req_ch,
   mded_rsp_if.source rsp_ch
);
   mded_pkg::edge_cmd_type push_cmd, head;
   logic push, full, pop, empty, clearing;

   mded_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .clearing (clearing),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full)
   );

   mded_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head     (head)
   );

   mded_back #(
      .EDGE_CAPACITY (EDGE_CAPACITY),
      .HASH_SLOTS    (HASH_SLOTS),
      .VERTEX_BITS   (VERTEX_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head     (head),
      .pop      (pop),
      .clearing (clearing),
      .rsp_ch   (rsp_ch)
   );
endmodule

// ===== test/tb_top.sv =====
module tb_top;

   localparam int EDGE_CAP   = 4096;
   localparam int SLOT_COUNT = 8192;
   localparam int CYCLE_LIMIT = 900000;

   typedef struct packed {
      logic [mded_pkg::VERTEX_W-1:0] va;
      logic [mded_pkg::VERTEX_W-1:0] vb;
      logic [mded_pkg::VERTEX_W-1:0] vc;
      logic                          fresh_mesh;
   } triangle_type;

   typedef struct packed {
      logic [mded_pkg::EDGE_INDEX_W-1:0] edge_index;
      logic [mded_pkg::VERTEX_W-1:0]     start_vertex;
      logic [mded_pkg::VERTEX_W-1:0]     end_vertex;
      logic                              is_new;
      logic                              dropped;
      logic [mded_pkg::EDGE_TOTAL_W-1:0] edge_total;
      logic                              last_of_triangle;
   } edge_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mded_req_if req_ch ();
   mded_rsp_if rsp_ch ();

   mesh_directed_edge_dedup dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state: hashed key table
   bit        slot_used [SLOT_COUNT];
   bit [31:0] slot_key  [SLOT_COUNT];
   int        slot_idx  [SLOT_COUNT];
   int        edges_stored;

   triangle_type    triangle_q [$];
   edge_result_type expected_edges [$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  triangles_sent = 0;
   int  edges_checked = 0;
   int  drops_seen = 0;
   bit  stim_done = 1'b0;
   bit  quiet_tail = 1'b0;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  recv_stall = 0;

   function automatic int slot_hash(bit [31:0] key);
      bit [63:0] h;
      h = {32'b0, key} * 64'h9E3779B97F4A7C15;
      h = h ^ (h >> 29);
      return int'(h % SLOT_COUNT);
   endfunction

   function automatic edge_result_type lookup_edge(bit [15:0] s, bit [15:0] e, bit last);
      edge_result_type r;
      bit [31:0] key;
      int pos;
      key = {e, s};
      pos = slot_hash(key);
      r = '0;
      r.start_vertex = s;
      r.end_vertex = e;
      r.last_of_triangle = last;
      r.dropped = 1'b1;
      for (int p = 0; p < SLOT_COUNT; p++) begin
         if (!slot_used[pos]) begin
            if (edges_stored < EDGE_CAP) begin
               slot_used[pos] = 1'b1;
               slot_key[pos] = key;
               slot_idx[pos] = edges_stored;
               r.edge_index = edges_stored[mded_pkg::EDGE_INDEX_W-1:0];
               edges_stored++;
               r.is_new = 1'b1;
               r.dropped = 1'b0;
            end
            break;
         end
         if (slot_key[pos] == key) begin
            r.edge_index = slot_idx[pos][mded_pkg::EDGE_INDEX_W-1:0];
            r.dropped = 1'b0;
            break;
         end
         pos = (pos + 1) % SLOT_COUNT;
      end
      r.edge_total = edges_stored[mded_pkg::EDGE_TOTAL_W-1:0];
      return r;
   endfunction

   task automatic predict_triangle(triangle_type t);
      if (t.fresh_mesh) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         edges_stored = 0;
      end
      expected_edges.push_back(lookup_edge(t.va, t.vb, 1'b0));
      expected_edges.push_back(lookup_edge(t.vb, t.vc, 1'b0));
      expected_edges.push_back(lookup_edge(t.vc, t.va, 1'b1));
   endtask

   function automatic triangle_type make_tri(int a, int b, int c, bit nm);
      triangle_type t;
      t.va = a[15:0];
      t.vb = b[15:0];
      t.vc = c[15:0];
      t.fresh_mesh = nm;
      return t;
   endfunction

   // stimulus
   initial begin
      int base;
      int pool;
      triangle_q.push_back(make_tri(0, 0, 0, 1'b1));
      triangle_q.push_back(make_tri(65535, 65535, 65535, 1'b0));
      triangle_q.push_back(make_tri(0, 65535, 0, 1'b0));
      triangle_q.push_back(make_tri(65535, 0, 65535, 1'b0));
      triangle_q.push_back(make_tri(1, 2, 3, 1'b0));
      triangle_q.push_back(make_tri(3, 2, 1, 1'b0));   // reversed edges are distinct
      triangle_q.push_back(make_tri(2, 3, 1, 1'b0));   // all edges already known
      triangle_q.push_back(make_tri(16'h5555, 16'haaaa, 16'h5555, 1'b0));
      triangle_q.push_back(make_tri(1, 2, 3, 1'b1));   // new mesh restarts indices
      triangle_q.push_back(make_tri(7, 7, 8, 1'b0));
      // long run of fresh edges, then repeats
      for (int i = 0; i < 100; i++)
         triangle_q.push_back(make_tri(3 * i + 100, 3 * i + 101, 3 * i + 102, i == 0));
      triangle_q.push_back(make_tri(100, 101, 102, 1'b0));
      triangle_q.push_back(make_tri(9, 10, 11, 1'b0));
      // random meshes over small vertex pools so that edges repeat
      for (int i = 0; i < 248; i++) begin
         if (i % 40 == 0) begin
            pool = $urandom_range(3, 60);
            base = $urandom_range(0, 65535 - 60);
         end
         if ($urandom_range(0, 9) == 0)
            triangle_q.push_back(make_tri($urandom, $urandom, $urandom, $urandom_range(0, 1)));
         else
            triangle_q.push_back(make_tri(base + $urandom_range(0, pool),
                                          base + $urandom_range(0, pool),
                                          base + $urandom_range(0, pool),
                                          (i % 40 == 0) || ($urandom_range(0, 60) == 0)));
      end
      stim_done = 1'b1;
   end

   // driver
   initial begin
      req_ch.valid = 1'b0;
      req_ch.vertex_a = '0;
      req_ch.vertex_b = '0;
      req_ch.vertex_c = '0;
      req_ch.new_mesh = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_ch.valid && !req_taken) begin
            // hold the pending transaction
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (triangle_q.size() > 0 && stim_done) begin
            if (!quiet_tail && triangle_q.size() > 1 && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(1, 6);
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid <= 1'b1;
               req_ch.vertex_a <= triangle_q[0].va;
               req_ch.vertex_b <= triangle_q[0].vb;
               req_ch.vertex_c <= triangle_q[0].vc;
               req_ch.new_mesh <= triangle_q[0].fresh_mesh;
               triangle_q.pop_front();
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
         quiet_tail <= stim_done && triangle_q.size() < 60;
         if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            recv_stall <= $urandom_range(1, 6) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      edge_result_type got;
      edge_result_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            predict_triangle(make_tri(req_ch.vertex_a, req_ch.vertex_b, req_ch.vertex_c,
                                      req_ch.new_mesh));
            triangles_sent <= triangles_sent + 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.edge_index = rsp_ch.edge_index;
            got.start_vertex = rsp_ch.start_vertex;
            got.end_vertex = rsp_ch.end_vertex;
            got.is_new = rsp_ch.is_new;
            got.dropped = rsp_ch.dropped;
            got.edge_total = rsp_ch.edge_total;
            got.last_of_triangle = rsp_ch.last_of_triangle;
            if (expected_edges.size() == 0) begin
               $display("%0t: unexpected edge result %p", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = expected_edges.pop_front();
               if (got !== want) begin
                  $display("%0t: edge mismatch expected %p actual %p", $time, want, got);
                  error_count <= error_count + 1;
               end
               if (want.dropped) drops_seen <= drops_seen + 1;
               edges_checked <= edges_checked + 1;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (!reset);
      fork
         begin
            wait (stim_done && triangle_q.size() == 0 && !req_ch.valid
                  && expected_edges.size() == 0);
            repeat (50) @(posedge clock);
         end
         wait (cycle_count >= CYCLE_LIMIT);
      join_any
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d edges outstanding", expected_edges.size());
         $display("*** FAILED ***");
      end else begin
         $display("%0d triangles sent, %0d edge results checked, %0d dropped",
                  triangles_sent, edges_checked, drops_seen);
         if (error_count == 0 && expected_edges.size() == 0)
            $display("*** PASSED ***");
         else
            $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
